>>> rtl/tpst_pkg.sv
`timescale 1ns / 1ps
package tpst_pkg;

   localparam int NUM_ENTRIES_DEF = 8;

   localparam int OP_W       = 2;
   localparam int IDX_PORT_W = 3;
   localparam int WIN_PORT_W = 4;
   localparam int TIME_W     = 32;
   localparam int PRIO_W     = 8;

   localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
   localparam logic [OP_W-1:0] OP_DISABLE = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] stop;
      logic [TIME_W-1:0] period;
      logic [PRIO_W-1:0] prio;
   } sched_entry_type;

   typedef struct packed {
      logic load_item;
      logic eval_tick;
      logic eval_single;
      logic last;
   } dp_cmd_type;

endpackage

>>> rtl/tpst_ctrl.sv
`timescale 1ns / 1ps
module tpst_ctrl
   import tpst_pkg::*;
#(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [OP_W-1:0]   req_operation,
   input  logic              out_free,
   output logic              req_ready,
   output dp_cmd_type        cmd,
   output logic [IDX_W-1:0]  entry_idx,
   output logic [IDX_W-1:0]  rd_idx
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_TICK   = 2'd1;
   localparam logic [1:0] ST_SINGLE = 2'd2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      cmd       = '0;
      rd_idx    = k_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // keep entry 0 prefetched for the next tick
            rd_idx    = '0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               k_in          = '0;
               state_in      = (req_operation == OP_TICK) ? ST_TICK : ST_SINGLE;
            end
         end
         ST_TICK: begin
            if (out_free) begin
               cmd.eval_tick = 1'b1;
               cmd.last      = (k_ff == LAST_IDX);
               if (k_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in   = k_ff + IDX_W'(1);
                  rd_idx = k_ff + IDX_W'(1);
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               cmd.eval_single = 1'b1;
               cmd.last        = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign entry_idx = k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

endmodule

>>> rtl/tpst_dp.sv
`timescale 1ns / 1ps
module tpst_dp
   import tpst_pkg::*;
#(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
   localparam int WIN_W = $clog2(NUM_ENTRIES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [IDX_W-1:0]      entry_idx,
   input  logic [IDX_W-1:0]      rd_idx,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [IDX_PORT_W-1:0] req_entry_index,
   input  logic [TIME_W-1:0]     req_current_time,
   input  logic [TIME_W-1:0]     req_start_time,
   input  logic [TIME_W-1:0]     req_end_time,
   input  logic [TIME_W-1:0]     req_repeat_period,
   input  logic [PRIO_W-1:0]     req_priority_level,
   input  logic                  rsp_ready,
   output logic                  out_free,
   output logic                  rsp_valid,
   output logic [IDX_PORT_W-1:0] rsp_entry_number,
   output logic                  rsp_turned_off,
   output logic                  rsp_turned_on,
   output logic                  rsp_actions_applied,
   output logic                  rsp_request_refresh,
   output logic [WIN_PORT_W-1:0] rsp_winner_index,
   output logic                  rsp_last
);

   localparam logic [WIN_W-1:0] NO_WINNER = WIN_W'(NUM_ENTRIES);

   // latched item
   logic [OP_W-1:0]       op_ff;
   logic [IDX_PORT_W-1:0] idx_ff;
   logic [TIME_W-1:0]     now_ff;
   sched_entry_type       new_ff;

   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [NUM_ENTRIES-1:0] active_ff;
   logic [WIN_W-1:0]       winner_ff, winner_in;
   logic [PRIO_W-1:0]      win_prio_ff;

   sched_entry_type mem [NUM_ENTRIES];
   sched_entry_type rd_ff;

   logic                  rsp_valid_ff;
   logic [IDX_PORT_W-1:0] rsp_entry_ff;
   logic                  rsp_off_ff;
   logic                  rsp_on_ff;
   logic                  rsp_applied_ff;
   logic                  rsp_refresh_ff;
   logic [WIN_PORT_W-1:0] rsp_winner_ff;
   logic                  rsp_last_ff;

   // tick evaluation of the visited entry
   logic            cur_valid;
   logic            cur_active;
   logic            expire;
   logic            recur;
   sched_entry_type upd;
   logic [WIN_W-1:0] win_mid;
   logic            in_window;
   logic            take;
   logic [WIN_W-1:0] tick_winner;

   // load, disable and unknown items
   logic [IDX_W-1:0] sel;
   logic             in_range;
   logic             single_off;

   always_comb begin
      cur_valid  = valid_ff[entry_idx];
      cur_active = active_ff[entry_idx];
      expire     = cur_valid && cur_active && (now_ff >= rd_ff.stop);
      recur      = (rd_ff.period != '0);
      upd        = rd_ff;
      if (expire && recur) begin
         upd.start = rd_ff.start + rd_ff.period;
         upd.stop  = rd_ff.stop + rd_ff.period;
      end
      // any expiry drops the winner, even a different one
      win_mid     = expire ? NO_WINNER : winner_ff;
      in_window   = cur_valid && (now_ff >= upd.start) && (now_ff < upd.stop);
      take        = in_window && ((win_mid == NO_WINNER) || (rd_ff.prio < win_prio_ff));
      tick_winner = take ? WIN_W'(entry_idx) : win_mid;
   end

   always_comb begin
      sel        = IDX_W'(idx_ff);
      in_range   = ((op_ff == OP_LOAD) || (op_ff == OP_DISABLE)) &&
                   (32'(idx_ff) < NUM_ENTRIES);
      single_off = in_range && active_ff[sel];
   end

   always_comb begin
      winner_in = winner_ff;
      if (cmd.eval_tick) begin
         winner_in = tick_winner;
      end else if (cmd.eval_single && single_off) begin
         winner_in = NO_WINNER;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         active_ff    <= '0;
         winner_ff    <= NO_WINNER;
         rsp_valid_ff <= 1'b0;
      end else begin
         winner_ff <= winner_in;
         if (cmd.eval_tick) begin
            if (expire && !recur) begin
               valid_ff[entry_idx] <= 1'b0;
            end
            // a preempted entry keeps its active flag
            if (take) begin
               active_ff[entry_idx] <= 1'b1;
            end else if (expire) begin
               active_ff[entry_idx] <= 1'b0;
            end
         end
         if (cmd.eval_single && in_range) begin
            active_ff[sel] <= 1'b0;
            valid_ff[sel]  <= (op_ff == OP_LOAD);
         end
         if (cmd.eval_tick || cmd.eval_single) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff         <= req_operation;
         idx_ff        <= req_entry_index;
         now_ff        <= req_current_time;
         new_ff.start  <= req_start_time;
         new_ff.stop   <= req_end_time;
         new_ff.period <= req_repeat_period;
         new_ff.prio   <= req_priority_level;
      end
      if (cmd.eval_tick && take) begin
         win_prio_ff <= rd_ff.prio;
      end
      if (cmd.eval_tick) begin
         rsp_entry_ff   <= IDX_PORT_W'(entry_idx);
         rsp_off_ff     <= expire;
         rsp_on_ff      <= take;
         rsp_applied_ff <= cur_valid && (tick_winner == WIN_W'(entry_idx));
         rsp_refresh_ff <= expire || take;
         rsp_winner_ff  <= WIN_PORT_W'(winner_in);
         rsp_last_ff    <= cmd.last;
      end else if (cmd.eval_single) begin
         rsp_entry_ff   <= idx_ff;
         rsp_off_ff     <= single_off;
         rsp_on_ff      <= 1'b0;
         rsp_applied_ff <= 1'b0;
         rsp_refresh_ff <= 1'b0;
         rsp_winner_ff  <= WIN_PORT_W'(winner_in);
         rsp_last_ff    <= cmd.last;
      end
   end

   // entry table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.eval_tick && expire && recur) begin
         mem[entry_idx] <= upd;
      end else if (cmd.eval_single && in_range && (op_ff == OP_LOAD)) begin
         mem[sel] <= new_ff;
      end
      rd_ff <= mem[rd_idx];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_entry_number    = rsp_entry_ff;
   assign rsp_turned_off      = rsp_off_ff;
   assign rsp_turned_on       = rsp_on_ff;
   assign rsp_actions_applied = rsp_applied_ff;
   assign rsp_request_refresh = rsp_refresh_ff;
   assign rsp_winner_index    = rsp_winner_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

>>> rtl/timed_priority_schedule_table.sv
`timescale 1ns / 1ps
// Schedule table of NUM_ENTRIES time windows with a single winning entry. An item is
// taken only while the block is idle. A tick walks the table one entry per cycle
// while results are not stalled, through the single read port of the entry memory,
// giving one result per entry; a load, a disable or an unknown operation gives one
// result. No item is taken until the last result of the current one is registered,
// and a stalled result holds the walk in place. A window holds while now is at least
// start and below stop, unsigned, and a period moves it on modulo 2^32. winner_index
// equal to NUM_ENTRIES means no winner; unloaded entries, being invalid, go unused.
module timed_priority_schedule_table
   import tpst_pkg::*;
#(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [IDX_PORT_W-1:0] req_entry_index,
   input  logic [TIME_W-1:0]     req_current_time,
   input  logic [TIME_W-1:0]     req_start_time,
   input  logic [TIME_W-1:0]     req_end_time,
   input  logic [TIME_W-1:0]     req_repeat_period,
   input  logic [PRIO_W-1:0]     req_priority_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDX_PORT_W-1:0] rsp_entry_number,
   output logic                  rsp_turned_off,
   output logic                  rsp_turned_on,
   output logic                  rsp_actions_applied,
   output logic                  rsp_request_refresh,
   output logic [WIN_PORT_W-1:0] rsp_winner_index,
   output logic                  rsp_last
);

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   dp_cmd_type       cmd;
   logic [IDX_W-1:0] entry_idx;
   logic [IDX_W-1:0] rd_idx;
   logic             out_free;

   tpst_ctrl #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_operation(req_operation),
      .out_free     (out_free),
      .req_ready    (req_ready),
      .cmd          (cmd),
      .entry_idx    (entry_idx),
      .rd_idx       (rd_idx)
   );

   tpst_dp #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .entry_idx          (entry_idx),
      .rd_idx             (rd_idx),
      .req_operation      (req_operation),
      .req_entry_index    (req_entry_index),
      .req_current_time   (req_current_time),
      .req_start_time     (req_start_time),
      .req_end_time       (req_end_time),
      .req_repeat_period  (req_repeat_period),
      .req_priority_level (req_priority_level),
      .rsp_ready          (rsp_ready),
      .out_free           (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_entry_number   (rsp_entry_number),
      .rsp_turned_off     (rsp_turned_off),
      .rsp_turned_on      (rsp_turned_on),
      .rsp_actions_applied(rsp_actions_applied),
      .rsp_request_refresh(rsp_request_refresh),
      .rsp_winner_index   (rsp_winner_index),
      .rsp_last           (rsp_last)
   );

   // a new winner always reapplies its actions and asks for a refresh
   a_on_applied : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_turned_on |-> rsp_actions_applied && rsp_request_refresh)
      else $error("winner result without applied actions or refresh");

   // turning an entry off leaves no winner unless the same step picked one
   a_off_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_turned_off && !rsp_turned_on |->
         rsp_winner_index == WIN_PORT_W'(NUM_ENTRIES))
      else $error("winner survived a turn off");

   // an accepted item keeps the block busy on the next cycle
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous one still in progress");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import tpst_pkg::*;

   localparam logic [OP_W-1:0]       OP_UNUSED    = 2'd3;
   localparam logic [WIN_PORT_W-1:0] NO_WINNER    = WIN_PORT_W'(NUM_ENTRIES_DEF);
   localparam int                    RANDOM_ITEMS = 285;
   localparam int                    STALL_LIMIT  = 2000;
   localparam int                    LONG_HOLD    = 200;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [IDX_PORT_W-1:0] idx;
      logic [TIME_W-1:0]     now;
      logic [TIME_W-1:0]     start;
      logic [TIME_W-1:0]     stop;
      logic [TIME_W-1:0]     period;
      logic [PRIO_W-1:0]     prio;
   } sched_item_type;

   typedef struct packed {
      logic [IDX_PORT_W-1:0] entry;
      logic                  off;
      logic                  on;
      logic                  applied;
      logic                  refresh;
      logic [WIN_PORT_W-1:0] winner;
      logic                  last;
   } sched_result_type;

   typedef struct packed {
      sched_item_type   item;
      logic             typed;
      sched_result_type res;
   } stim_row_type;

   logic                  clock;
   logic                  reset               = 1'b1;
   logic                  req_valid           = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_operation       = OP_TICK;
   logic [IDX_PORT_W-1:0] req_entry_index     = '0;
   logic [TIME_W-1:0]     req_current_time    = '0;
   logic [TIME_W-1:0]     req_start_time      = '0;
   logic [TIME_W-1:0]     req_end_time        = '0;
   logic [TIME_W-1:0]     req_repeat_period   = '0;
   logic [PRIO_W-1:0]     req_priority_level  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready           = 1'b0;
   logic [IDX_PORT_W-1:0] rsp_entry_number;
   logic                  rsp_turned_off;
   logic                  rsp_turned_on;
   logic                  rsp_actions_applied;
   logic                  rsp_request_refresh;
   logic [WIN_PORT_W-1:0] rsp_winner_index;
   logic                  rsp_last;

   timed_priority_schedule_table uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_entry_index     (req_entry_index),
      .req_current_time    (req_current_time),
      .req_start_time      (req_start_time),
      .req_end_time        (req_end_time),
      .req_repeat_period   (req_repeat_period),
      .req_priority_level  (req_priority_level),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_entry_number    (rsp_entry_number),
      .rsp_turned_off      (rsp_turned_off),
      .rsp_turned_on       (rsp_turned_on),
      .rsp_actions_applied (rsp_actions_applied),
      .rsp_request_refresh (rsp_request_refresh),
      .rsp_winner_index    (rsp_winner_index),
      .rsp_last            (rsp_last)
   );

   // shadow copy of the schedule table
   bit                    ent_valid  [NUM_ENTRIES_DEF];
   bit                    ent_active [NUM_ENTRIES_DEF];
   logic [TIME_W-1:0]     ent_start  [NUM_ENTRIES_DEF];
   logic [TIME_W-1:0]     ent_stop   [NUM_ENTRIES_DEF];
   logic [TIME_W-1:0]     ent_period [NUM_ENTRIES_DEF];
   logic [PRIO_W-1:0]     ent_prio   [NUM_ENTRIES_DEF];
   logic [WIN_PORT_W-1:0] cur_winner = NO_WINNER;

   sched_result_type schedule_events [$];
   stim_row_type     directed_rows [$];
   logic [TIME_W-1:0] time_base = 32'h2000;
   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   bit  no_idle        = 1'b0;
   bit  hold_request   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic predict_schedule(input sched_item_type it);
      sched_result_type r;
      int i;
      if (it.op == OP_TICK) begin
         for (i = 0; i < NUM_ENTRIES_DEF; i++) begin
            r = '0;
            r.entry = IDX_PORT_W'(i);
            if (ent_valid[i]) begin
               if (ent_active[i] && it.now >= ent_stop[i]) begin
                  ent_active[i] = 1'b0;
                  cur_winner = NO_WINNER;
                  r.off = 1'b1;
                  r.refresh = 1'b1;
                  if (ent_period[i] != 0) begin
                     ent_start[i] += ent_period[i];
                     ent_stop[i] += ent_period[i];
                  end else begin
                     ent_valid[i] = 1'b0;
                  end
               end
               // ties keep the current winner, a preempted entry stays active
               if (it.now >= ent_start[i] && it.now < ent_stop[i] &&
                   (cur_winner == NO_WINNER ||
                    ent_prio[i] < ent_prio[cur_winner[IDX_PORT_W-1:0]])) begin
                  ent_active[i] = 1'b1;
                  cur_winner = WIN_PORT_W'(i);
                  r.on = 1'b1;
                  r.refresh = 1'b1;
               end
               r.applied = (cur_winner == i);
            end
            r.winner = cur_winner;
            r.last = (i == NUM_ENTRIES_DEF - 1);
            schedule_events.push_back(r);
         end
      end else begin
         r = '0;
         r.entry = it.idx;
         r.last = 1'b1;
         if ((it.op == OP_LOAD || it.op == OP_DISABLE) && it.idx < NUM_ENTRIES_DEF) begin
            // any power-off drops the winner, whoever it is
            if (ent_active[it.idx]) begin
               ent_active[it.idx] = 1'b0;
               cur_winner = NO_WINNER;
               r.off = 1'b1;
            end
            ent_valid[it.idx] = (it.op == OP_LOAD);
            if (it.op == OP_LOAD) begin
               ent_start[it.idx] = it.start;
               ent_stop[it.idx] = it.stop;
               ent_period[it.idx] = it.period;
               ent_prio[it.idx] = it.prio;
            end
         end
         r.winner = cur_winner;
         schedule_events.push_back(r);
      end
   endtask

   function automatic int idle_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic stim_row_type tick_row(input logic [TIME_W-1:0] now);
      stim_row_type r;
      r = '0;
      r.item.op = OP_TICK;
      r.item.now = now;
      return r;
   endfunction

   function automatic stim_row_type cmd_row(input logic [OP_W-1:0] op,
                                            input logic [IDX_PORT_W-1:0] idx,
                                            input logic [TIME_W-1:0] start,
                                            input logic [TIME_W-1:0] stop,
                                            input logic [TIME_W-1:0] period,
                                            input logic [PRIO_W-1:0] prio,
                                            input logic off,
                                            input logic [WIN_PORT_W-1:0] win);
      stim_row_type r;
      r = '0;
      r.item.op = op;
      r.item.idx = idx;
      r.item.now = start;
      r.item.start = start;
      r.item.stop = stop;
      r.item.period = period;
      r.item.prio = prio;
      r.typed = 1'b1;
      r.res.entry = idx;
      r.res.off = off;
      r.res.winner = win;
      r.res.last = 1'b1;
      return r;
   endfunction

   // mostly windows around a slowly advancing clock, plus some noise
   function automatic sched_item_type random_item();
      sched_item_type it;
      int r;
      it.op = OP_TICK;
      it.idx = IDX_PORT_W'($urandom_range(0, 7));
      it.now = $urandom;
      it.start = $urandom;
      it.stop = $urandom;
      it.period = $urandom;
      it.prio = PRIO_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 45) begin
         time_base += (r < 3) ? $urandom_range(50, 2000) : $urandom_range(0, 6);
         it.now = time_base;
      end else if (r < 80) begin
         it.op = OP_LOAD;
         it.start = time_base + $urandom_range(0, 24) - 4;
         it.stop = it.start + $urandom_range(1, 25);
         // empty or inverted window
         if (r < 48) it.stop = it.start - $urandom_range(0, 3);
         it.period = (r < 64) ? 0 : (r < 77) ? $urandom_range(1, 40) : $urandom;
         if (r[0]) it.prio = PRIO_W'($urandom_range(0, 7));
      end else if (r < 88) begin
         it.op = OP_DISABLE;
      end else if (r < 92) begin
         it.op = OP_UNUSED;
      end else begin
         it.op = OP_W'($urandom_range(0, 3));
      end
      return it;
   endfunction

   task automatic offer_item(input sched_item_type it, input logic typed,
                             input sched_result_type typed_res);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= it.op;
      req_entry_index <= it.idx;
      req_current_time <= it.now;
      req_start_time <= it.start;
      req_end_time <= it.stop;
      req_repeat_period <= it.period;
      req_priority_level <= it.prio;
      do @(posedge clock); while (!req_ready);
      predict_schedule(it);
      if (typed) schedule_events[$] = typed_res;
   endtask

   function automatic logic field_ok(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (got === want) return 1'b1;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      sched_result_type want;
      logic ok;
      if (!reset && rsp_valid && rsp_ready) begin
         if (schedule_events.size() == 0) begin
            $display("%0t: unexpected item, entry %0d expected none", $time,
                     rsp_entry_number);
            mismatch_count++;
         end else begin
            want = schedule_events.pop_front();
            ok = field_ok("entry_number", 32'(want.entry), 32'(rsp_entry_number)) &
                 field_ok("turned_off", 32'(want.off), 32'(rsp_turned_off)) &
                 field_ok("turned_on", 32'(want.on), 32'(rsp_turned_on)) &
                 field_ok("actions_applied", 32'(want.applied),
                          32'(rsp_actions_applied)) &
                 field_ok("request_refresh", 32'(want.refresh),
                          32'(rsp_request_refresh)) &
                 field_ok("winner_index", 32'(want.winner), 32'(rsp_winner_index)) &
                 field_ok("last", 32'(want.last), 32'(rsp_last));
            if (!ok) mismatch_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side backpressure
   initial begin
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (1 + idle_gap()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      int n;
      directed_rows = '{
         cmd_row(OP_DISABLE, 0, 0, 0, 0, 0, 1'b0, NO_WINNER),
         cmd_row(OP_UNUSED, 7, '1, '1, '1, '1, 1'b0, NO_WINNER),
         tick_row(0),
         cmd_row(OP_LOAD, 0, 100, 200, 0, 10, 1'b0, NO_WINNER),
         cmd_row(OP_LOAD, 1, 150, 300, 1000, 5, 1'b0, NO_WINNER),
         cmd_row(OP_LOAD, 7, 0, '1, '1, '1, 1'b0, NO_WINNER),
         tick_row(120),
         tick_row(160),
         tick_row(200),
         tick_row(300),
         cmd_row(OP_LOAD, 7, 0, 0, 0, 0, 1'b1, NO_WINNER),
         tick_row(1200),
         cmd_row(OP_DISABLE, 1, 0, 0, 0, 0, 1'b1, NO_WINNER),
         cmd_row(OP_LOAD, 2, 32'hFFFF_FF00, 32'hFFFF_FFF0, 32'h200, 3, 1'b0, NO_WINNER),
         tick_row(32'hFFFF_FF80),
         tick_row('1),
         tick_row(32'h150),
         cmd_row(OP_LOAD, 3, 0, 32'h1000, 0, 3, 1'b0, 4'd2),
         tick_row(32'h160),
         cmd_row(OP_DISABLE, 3, 0, 0, 0, 0, 1'b0, 4'd2),
         cmd_row(OP_LOAD, 4, 0, 32'h1000, 5, 0, 1'b0, 4'd2),
         tick_row(32'h170),
         cmd_row(OP_DISABLE, 2, 0, 0, 0, 0, 1'b1, NO_WINNER),
         tick_row(32'h1000),
         cmd_row(OP_UNUSED, 0, 0, 0, 0, 0, 1'b0, 4'd4)
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[k])
         offer_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].res);
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 60) hold_request = 1'b1;
         if (n == 150) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (schedule_events.size() != 0);
         end
         no_idle = (n >= 200 && n < 240);
         // occasionally jump the clock, often close to the wrap point
         if (n % 80 == 40)
            time_base = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 60);
         offer_item(random_item(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (schedule_events.size() != 0) @(posedge clock);
      repeat (2 * NUM_ENTRIES_DEF) @(posedge clock);
      if (mismatch_count == 0 && schedule_events.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> timed_priority_schedule_table.f
rtl/tpst_pkg.sv
rtl/tpst_ctrl.sv
rtl/tpst_dp.sv
rtl/timed_priority_schedule_table.sv
tb/tb_top.sv
